// ----- sv/cdg_pkg.sv -----
// Shared types and constants for the clock discipline governor.
package cdg_pkg;

  // Result action codes
  typedef enum logic [1:0] {
    ACT_UPDATE = 2'd0,
    ACT_COLD   = 2'd1,
    ACT_LARGE  = 2'd2
  } action_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_SLEW_DIV    = 3'd0,
    REG_SLEW_MAX_MS = 3'd1,
    REG_TSYNC_LIM   = 3'd2,
    REG_TSYNC_HYS   = 3'd3,
    REG_FREQ_DIV    = 3'd4,
    REG_FREQ_MAX    = 3'd5,
    REG_RSYNC_LIM   = 3'd6,
    REG_RSYNC_HYS   = 3'd7
  } reg_idx_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_MAG,
    ST_CLASS,
    ST_DIV1,
    ST_SLEW,
    ST_PDIFF,
    ST_PMAG,
    ST_DIV2,
    ST_PSIGN,
    ST_FMAG,
    ST_DIV3,
    ST_STEP,
    ST_SAVE,
    ST_DONE
  } state_t;

  localparam int unsigned CFG_W  = 30;
  localparam int unsigned TIME_W = 64;

  // Divider request from the sequencer
  typedef struct packed {
    logic              start;
    logic [TIME_W-1:0] num;
    logic [TIME_W-1:0] den;
  } div_req_t;

endpackage

// ----- sv/cdg_if.sv -----
// Valid/ready channel interfaces for sync events and results.
interface cdg_in_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] ext_time;
  logic               ext_complete;
  logic signed [63:0] int_time;
  logic signed [63:0] abs_time;
  logic               clock_is_set;

  modport source (output valid, ext_time, ext_complete, int_time, abs_time, clock_is_set,
                  input ready);
  modport sink   (input valid, ext_time, ext_complete, int_time, abs_time, clock_is_set,
                  output ready);
endinterface

interface cdg_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic signed [63:0] load_time;
  logic signed [31:0] slew_out;
  logic signed [31:0] ppb_out;
  logic               time_synced;
  logic               rate_synced;
  logic               offset_over_half_second;

  modport source (output valid, action, load_time, slew_out, ppb_out, time_synced,
                  rate_synced, offset_over_half_second, input ready);
  modport sink   (input valid, action, load_time, slew_out, ppb_out, time_synced,
                  rate_synced, offset_over_half_second, output ready);
endinterface

// ----- sv/cdg_div.sv -----
// Bit-serial restoring unsigned divider, one quotient bit per cycle.
module cdg_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cdg_pkg::div_req_t             req,
  output logic                          done,
  output logic [cdg_pkg::TIME_W-1:0]    quot
);
  localparam int unsigned W  = cdg_pkg::TIME_W;
  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  quo_r, quo_nxt;
  logic [W-1:0]  den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [W:0]    shifted;
  logic [W:0]    trial;

  // One restoring step: shift in the next dividend bit, try the subtract
  always_comb begin
    shifted = {rem_r, quo_r[W-1]};
    trial   = shifted - {1'b0, den_r};
    if (!trial[W]) begin
      rem_nxt = trial[W-1:0];
      quo_nxt = {quo_r[W-2:0], 1'b1};
    end else begin
      rem_nxt = shifted[W-1:0];
      quo_nxt = {quo_r[W-2:0], 1'b0};
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.num;
      den_r <= req.den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done = done_r;
  assign quot = quo_r;
endmodule

// ----- sv/clock_discipline_governor.sv -----
// Top level: sync event sequencer, configuration registers and result register.
//
// Usage: sync events enter on in_ch (valid/ready); each produces exactly one
// result on out_ch (valid/ready). Configuration registers are written through
// cfg_we/cfg_idx/cfg_wdata; the user must write them only while the block is
// idle, which the block itself does not enforce; writes take effect at once.
// A load event (cold start or large offset) does not use the divider. A normal
// update runs the shared 64-bit bit-serial divider once for the slew; with
// history and a nonzero period it runs it twice more for the period scaling
// and the ppb step (once more when the period is exactly one second and the
// scaling divide is skipped). The divider produces one quotient bit per cycle
// over 64 bits. One event is processed at a time; in_ch.ready is high only
// while the sequencer is idle, from the cycle after the result is registered.
// The result register frees the sequencer: a finished result waits there while
// the next event is accepted; a further result waits in the sequencer until
// the receiver takes the previous one.
// Reset clears the history, slew, ppb and both sync flags, and loads the
// configuration registers with their default values.
module clock_discipline_governor #(
  parameter int unsigned SECOND_SHIFT    = 30,
  parameter int unsigned MS_SHIFT        = 20,
  parameter int unsigned MAX_OFFSET_SECS = 3
) (
  input  logic         clk,
  input  logic         rst_n,
  cdg_in_if.sink       in_ch,
  cdg_out_if.source    out_ch,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_idx,
  input  logic [29:0]  cfg_wdata
);
  localparam int unsigned W = cdg_pkg::TIME_W;
  localparam logic [W-1:0] HALF_SEC = W'(1) << (SECOND_SHIFT - 1);
  localparam logic [W-1:0] ONE_SEC  = W'(1) << SECOND_SHIFT;
  localparam logic [W-1:0] MAX_OFF  = W'(MAX_OFFSET_SECS) << SECOND_SHIFT;

  // Hysteresis flag update on a magnitude
  function automatic logic hyst(input logic flag, input logic [W-1:0] mag,
                                input logic [W-1:0] limit, input logic [W-1:0] hys);
    logic f;
    f = flag;
    if (limit > hys && mag < limit - hys) f = 1'b1;
    if (mag > limit + hys) f = 1'b0;
    return f;
  endfunction

  // Configuration registers
  logic [10:0] slew_div_r, slew_max_r, freq_div_r;
  logic [29:0] tsync_lim_r, tsync_hys_r;
  logic [19:0] freq_max_r, rsync_lim_r, rsync_hys_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slew_div_r  <= 11'd10;
      slew_max_r  <= 11'd10;
      tsync_lim_r <= 30'd10000000;
      tsync_hys_r <= 30'd1000000;
      freq_div_r  <= 11'd10;
      freq_max_r  <= 20'd1000;
      rsync_lim_r <= 20'd1000;
      rsync_hys_r <= 20'd100;
    end else if (cfg_we) begin
      unique case (cdg_pkg::reg_idx_t'(cfg_idx))
        cdg_pkg::REG_SLEW_DIV:    slew_div_r  <= cfg_wdata[10:0];
        cdg_pkg::REG_SLEW_MAX_MS: slew_max_r  <= cfg_wdata[10:0];
        cdg_pkg::REG_TSYNC_LIM:   tsync_lim_r <= cfg_wdata;
        cdg_pkg::REG_TSYNC_HYS:   tsync_hys_r <= cfg_wdata;
        cdg_pkg::REG_FREQ_DIV:    freq_div_r  <= cfg_wdata[10:0];
        cdg_pkg::REG_FREQ_MAX:    freq_max_r  <= cfg_wdata[19:0];
        cdg_pkg::REG_RSYNC_LIM:   rsync_lim_r <= cfg_wdata[19:0];
        cdg_pkg::REG_RSYNC_HYS:   rsync_hys_r <= cfg_wdata[19:0];
        default: ;
      endcase
    end
  end

  // Sequencer state and working registers
  cdg_pkg::state_t state_r, state_nxt;
  logic [W-1:0] ext_r, int_r, abs_r;
  logic         complete_r, is_set_r;
  logic [W-1:0] diff_r, mag_r;
  logic [W-1:0] ext_per_r, int_per_r, pd_r, ppbd_r, pmag_r;
  logic         sgn_r;
  logic [1:0]   act_r;
  logic [W-1:0] load_r;
  logic         over_r;

  // Persistent governor state
  logic [W-1:0] last_int_r, last_ext_r;
  logic         hist_r;
  logic [31:0]  slew_r, ppb_r;
  logic         tflag_r, rflag_r;

  // Result register
  logic         out_valid_r;
  logic [1:0]   o_act_r;
  logic [W-1:0] o_load_r;
  logic [31:0]  o_slew_r, o_ppb_r;
  logic         o_tflag_r, o_rflag_r, o_over_r;

  cdg_pkg::div_req_t div_req;
  logic              div_done;
  logic [W-1:0]      div_q;

  cdg_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .done (div_done),
    .quot (div_q)
  );

  // Combinational helpers
  logic         cold;
  logic         big_off;
  logic [W-1:0] pd_c, pshift, pnum, pden, pm_c;
  logic [W-1:0] lim, qc;
  logic         slew_neg;
  logic [19:0]  step_mag;
  logic signed [33:0] np;
  logic         out_free;

  always_comb begin
    cold     = !is_set_r && complete_r;
    big_off  = !cold && (mag_r > MAX_OFF);
    pd_c     = int_per_r - ext_per_r;
    pshift   = pd_r << SECOND_SHIFT;
    pnum     = pshift[W-1] ? -pshift : pshift;
    pden     = ext_per_r[W-1] ? -ext_per_r : ext_per_r;
    pm_c     = ppbd_r[W-1] ? -ppbd_r : ppbd_r;
    lim      = W'(slew_max_r) << MS_SHIFT;
    qc       = (div_q > lim) ? lim : div_q;
    slew_neg = !diff_r[W-1] && (diff_r != '0);
    if (slew_neg && qc > W'(64'h8000_0000)) qc = W'(64'h8000_0000);
    if (!slew_neg && qc > W'(64'h7FFF_FFFF)) qc = W'(64'h7FFF_FFFF);
    step_mag = (div_q > W'(freq_max_r)) ? freq_max_r : div_q[19:0];
    if (ppbd_r[W-1]) np = 34'(signed'(ppb_r)) + 34'(step_mag);
    else np = 34'(signed'(ppb_r)) - 34'(step_mag);
    out_free = !out_valid_r || out_ch.ready;
  end

  // Next state and divider requests
  always_comb begin
    state_nxt   = state_r;
    div_req     = '0;
    unique case (state_r)
      cdg_pkg::ST_IDLE:  if (in_ch.valid) state_nxt = cdg_pkg::ST_DIFF;
      cdg_pkg::ST_DIFF:  state_nxt = cdg_pkg::ST_MAG;
      cdg_pkg::ST_MAG:   state_nxt = cdg_pkg::ST_CLASS;
      cdg_pkg::ST_CLASS: begin
        if (cold || big_off) begin
          state_nxt = cdg_pkg::ST_DONE;
        end else begin
          div_req.start = 1'b1;
          div_req.num   = mag_r;
          div_req.den   = (slew_div_r == '0) ? W'(1) : W'(slew_div_r);
          state_nxt     = cdg_pkg::ST_DIV1;
        end
      end
      cdg_pkg::ST_DIV1:  if (div_done) state_nxt = cdg_pkg::ST_SLEW;
      cdg_pkg::ST_SLEW:  state_nxt = cdg_pkg::ST_PDIFF;
      cdg_pkg::ST_PDIFF: begin
        if (!hist_r || ext_per_r == '0) state_nxt = cdg_pkg::ST_SAVE;
        else if (ext_per_r == ONE_SEC) state_nxt = cdg_pkg::ST_FMAG;
        else state_nxt = cdg_pkg::ST_PMAG;
      end
      cdg_pkg::ST_PMAG: begin
        div_req.start = 1'b1;
        div_req.num   = pnum;
        div_req.den   = pden;
        state_nxt     = cdg_pkg::ST_DIV2;
      end
      cdg_pkg::ST_DIV2:  if (div_done) state_nxt = cdg_pkg::ST_PSIGN;
      cdg_pkg::ST_PSIGN: state_nxt = cdg_pkg::ST_FMAG;
      cdg_pkg::ST_FMAG: begin
        div_req.start = 1'b1;
        div_req.num   = pm_c;
        div_req.den   = (freq_div_r == '0) ? W'(1) : W'(freq_div_r);
        state_nxt     = cdg_pkg::ST_DIV3;
      end
      cdg_pkg::ST_DIV3:  if (div_done) state_nxt = cdg_pkg::ST_STEP;
      cdg_pkg::ST_STEP:  state_nxt = cdg_pkg::ST_SAVE;
      cdg_pkg::ST_SAVE:  state_nxt = cdg_pkg::ST_DONE;
      cdg_pkg::ST_DONE:  if (out_free) state_nxt = cdg_pkg::ST_IDLE;
      default:           state_nxt = cdg_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= cdg_pkg::ST_IDLE;
    else state_r <= state_nxt;
  end

  // Item working registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      cdg_pkg::ST_IDLE: begin
        ext_r      <= in_ch.ext_time;
        int_r      <= in_ch.int_time;
        abs_r      <= in_ch.abs_time;
        complete_r <= in_ch.ext_complete;
        is_set_r   <= in_ch.clock_is_set;
      end
      cdg_pkg::ST_DIFF:  diff_r <= abs_r - ext_r;
      cdg_pkg::ST_MAG:   mag_r  <= diff_r[W-1] ? -diff_r : diff_r;
      cdg_pkg::ST_CLASS: begin
        over_r <= !cold && (mag_r > HALF_SEC);
        if (cold) act_r <= cdg_pkg::ACT_COLD;
        else if (big_off) act_r <= cdg_pkg::ACT_LARGE;
        else act_r <= cdg_pkg::ACT_UPDATE;
        load_r <= (cold || big_off) ? ext_r : '0;
      end
      cdg_pkg::ST_SLEW: begin
        ext_per_r <= ext_r - last_ext_r;
        int_per_r <= int_r - last_int_r;
      end
      cdg_pkg::ST_PDIFF: begin
        pd_r   <= pd_c;
        ppbd_r <= pd_c;
      end
      cdg_pkg::ST_PMAG:  sgn_r <= pshift[W-1] ^ ext_per_r[W-1];
      cdg_pkg::ST_PSIGN: ppbd_r <= sgn_r ? -div_q : div_q;
      cdg_pkg::ST_FMAG:  pmag_r <= pm_c;
      default: ;
    endcase
  end

  // Governor state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_int_r <= '0;
      last_ext_r <= '0;
      hist_r     <= 1'b0;
      slew_r     <= '0;
      ppb_r      <= '0;
      tflag_r    <= 1'b0;
      rflag_r    <= 1'b0;
    end else begin
      unique case (state_r)
        cdg_pkg::ST_CLASS: begin
          if (cold || big_off) begin
            ppb_r      <= '0;
            hist_r     <= 1'b0;
            last_int_r <= '0;
            last_ext_r <= '0;
          end
        end
        cdg_pkg::ST_SLEW: begin
          slew_r  <= slew_neg ? -qc[31:0] : qc[31:0];
          tflag_r <= hyst(tflag_r, mag_r, W'(tsync_lim_r), W'(tsync_hys_r));
        end
        cdg_pkg::ST_STEP: begin
          if (np > 34'sh0_7FFF_FFFF) ppb_r <= 32'h7FFF_FFFF;
          else if (np < -34'sh0_8000_0000) ppb_r <= 32'h8000_0000;
          else ppb_r <= np[31:0];
          rflag_r <= hyst(rflag_r, pmag_r, W'(rsync_lim_r), W'(rsync_hys_r));
        end
        cdg_pkg::ST_SAVE: begin
          last_int_r <= int_r;
          last_ext_r <= ext_r;
          hist_r     <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == cdg_pkg::ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == cdg_pkg::ST_DONE && out_free) begin
      o_act_r   <= act_r;
      o_load_r  <= load_r;
      o_slew_r  <= slew_r;
      o_ppb_r   <= ppb_r;
      o_tflag_r <= tflag_r;
      o_rflag_r <= rflag_r;
      o_over_r  <= over_r;
    end
  end

  assign in_ch.ready                    = (state_r == cdg_pkg::ST_IDLE);
  assign out_ch.valid                   = out_valid_r;
  assign out_ch.action                  = o_act_r;
  assign out_ch.load_time               = o_load_r;
  assign out_ch.slew_out                = o_slew_r;
  assign out_ch.ppb_out                 = o_ppb_r;
  assign out_ch.time_synced             = o_tflag_r;
  assign out_ch.rate_synced             = o_rflag_r;
  assign out_ch.offset_over_half_second = o_over_r;
endmodule
